// File: hdl/lcd4_pkg.sv
package lcd4_pkg;

    // Command codes carried in the command field of an input transaction.
    localparam logic [1:0] CMD_INIT       = 2'd0;
    localparam logic [1:0] CMD_SET_POS    = 2'd1;
    localparam logic [1:0] CMD_WRITE_CHAR = 2'd2;

    // Controller instruction bits.
    localparam logic [7:0] OP_FUNCTION_SET = 8'h20;
    localparam logic [7:0] OP_FS_8BIT      = 8'h10;
    localparam logic [7:0] OP_FS_2LINES    = 8'h08;
    localparam logic [7:0] OP_DISPLAY_CTRL = 8'h08;
    localparam logic [7:0] OP_DISPLAY_ON   = 8'h04;
    localparam logic [7:0] OP_ENTRY_MODE   = 8'h04;
    localparam logic [7:0] OP_ENTRY_INC    = 8'h02;
    localparam logic [7:0] OP_CLEAR        = 8'h01;
    localparam logic [7:0] OP_SET_DDRAM    = 8'h80;

    localparam logic [7:0] CODE_FS_8BIT  = OP_FUNCTION_SET | OP_FS_8BIT;
    localparam logic [7:0] CODE_FS_2LINE = OP_FUNCTION_SET | OP_FS_2LINES;
    localparam logic [7:0] CODE_DISP_OFF = OP_DISPLAY_CTRL;
    localparam logic [7:0] CODE_ENTRY    = OP_ENTRY_MODE | OP_ENTRY_INC;
    localparam logic [7:0] CODE_DISP_ON  = OP_DISPLAY_CTRL | OP_DISPLAY_ON;

    // Extra waits in milliseconds.
    localparam logic [5:0] WAIT_POWER_UP_MS = 6'd50;
    localparam logic [2:0] WAIT_FIRST_MS    = 3'd5;
    localparam logic [2:0] WAIT_CMD_MS      = 3'd1;

    // The power-up sequence is fourteen strobes long.
    localparam int         STEP_W         = 4;
    localparam logic [3:0] INIT_LAST_STEP = 4'd13;

    // One queued command, already classified by the front end.
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic       split;
        logic [7:0] code;
        logic [2:0] wait_after;
    } entry_t;

    // One enable strobe as presented on the result channel.
    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [5:0] wait_before;
        logic [2:0] wait_after;
        logic       last;
    } strobe_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [6:0] line_base(input logic [1:0] row);
        logic [6:0] b;
        unique case (row)
            2'd0: b = 7'd0;
            2'd1: b = 7'd64;
            2'd2: b = 7'd20;
            2'd3: b = 7'd84;
            default: b = 7'd0;
        endcase
        return b;
    endfunction

    function automatic strobe_t init_strobe(input logic [3:0] step);
        strobe_t s;
        s = '0;
        unique case (step)
            4'd0: begin
                s.nibble      = CODE_FS_8BIT[7:4];
                s.wait_before = WAIT_POWER_UP_MS;
                s.wait_after  = WAIT_FIRST_MS;
            end
            4'd1, 4'd2: begin
                s.nibble     = CODE_FS_8BIT[7:4];
                s.wait_after = WAIT_CMD_MS;
            end
            4'd3: begin
                s.nibble     = OP_FUNCTION_SET[7:4];
                s.wait_after = WAIT_CMD_MS;
            end
            4'd4: s.nibble = CODE_FS_2LINE[7:4];
            4'd5: begin
                s.nibble     = CODE_FS_2LINE[3:0];
                s.wait_after = WAIT_CMD_MS;
            end
            4'd6: s.nibble = CODE_DISP_OFF[7:4];
            4'd7: begin
                s.nibble     = CODE_DISP_OFF[3:0];
                s.wait_after = WAIT_CMD_MS;
            end
            4'd8: s.nibble = OP_CLEAR[7:4];
            4'd9: begin
                s.nibble     = OP_CLEAR[3:0];
                s.wait_after = WAIT_CMD_MS;
            end
            4'd10: s.nibble = CODE_ENTRY[7:4];
            4'd11: begin
                s.nibble     = CODE_ENTRY[3:0];
                s.wait_after = WAIT_CMD_MS;
            end
            4'd12: s.nibble = CODE_DISP_ON[7:4];
            4'd13: begin
                s.nibble     = CODE_DISP_ON[3:0];
                s.wait_after = WAIT_CMD_MS;
                s.last       = 1'b1;
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/char_lcd_nibble_write_sequencer_core.sv
// Turns display commands into enable strobes for a character LCD on a 4-bit
// bus. Each input transaction is one command: initialize, set cursor
// position or write a character. Each output transaction is one strobe: the
// RS level and the nibble for D7..D4, the extra wait in ms before and after
// it, and tlast on the final strobe of the command. Initialize yields 14
// strobes and leaves the block in 4-bit mode; position and character yield
// two strobes in 4-bit mode and only the high nibble before it; a position
// with a row above three, or command code three, yields nothing. The front end
// accepts one command per cycle while the command queue has room, so a command
// is taken while earlier ones are still being sequenced. The back end emits
// one strobe per cycle through its output register while the receiver is
// ready and the queue holds a command. Its single strobe per cycle, with the
// receiver ready, sets the sustained rate.
module char_lcd_nibble_write_sequencer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [9:2] char_code, [15:10] column, [18:16] row, rest zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] reg_select, [4:1] nibble, [10:5] wait_before_ms, [13:11] wait_after_ms
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    lcd4_pkg::q_status_t q_stat;
    lcd4_pkg::entry_t    q_entry;
    lcd4_pkg::entry_t    q_head;
    lcd4_pkg::strobe_t   strobe;
    logic                q_push;
    logic                q_pop;
    logic                four_bit_mode;

    // The front end classifies commands and tracks the display's bus mode.
    lcd4_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .command       (s_tdata[1:0]),
        .char_code     (s_tdata[9:2]),
        .column        (s_tdata[15:10]),
        .row           (s_tdata[18:16]),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_entry       (q_entry),
        .four_bit_mode (four_bit_mode)
    );

    // Short queue that lets the front end keep accepting while the back end
    // is still working through a long strobe sequence.
    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_stat)
    );

    // The back end expands the head command into strobes, one per cycle while the output is not stalled.
    lcd4_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_strobe (strobe)
    );

    assign m_tdata = {2'b00, strobe.wait_after, strobe.wait_before,
                      strobe.nibble, strobe.reg_select};
    assign m_tlast = strobe.last;

    // A command is never written into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_stat.full)
        else $error("command queued while the queue is full");

    // A command is only retired from a queue that holds one.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_stat.empty)
        else $error("command retired from an empty queue");

    // Accepting an initialize command leaves the block in 4-bit mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[1:0] == lcd4_pkg::CMD_INIT)) |=> four_bit_mode)
        else $error("bus mode not switched after initialize");

    // Retiring a command always coincides with loading its final strobe.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |=> (m_tvalid && m_tlast))
        else $error("command retired without its final strobe");

endmodule

// File: hdl/lcd4_front.sv
module lcd4_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [7:0]            char_code,
    input  logic [5:0]            column,
    input  logic [2:0]            row,
    input  lcd4_pkg::q_status_t   q_stat,
    output logic                  q_push,
    output lcd4_pkg::entry_t      q_entry,
    output logic                  four_bit_mode
);

    logic             mode_reg;
    logic             mode_next;
    logic             accept;
    logic             produce;
    lcd4_pkg::entry_t entry;

    assign in_ready      = ~q_stat.full;
    assign accept        = in_valid & in_ready;
    assign q_push        = accept & produce;
    assign q_entry       = entry;
    assign four_bit_mode = mode_reg;

    // Positions and characters go out as two nibbles only once the
    // display has been switched to 4-bit transfers.
    always_comb begin
        entry   = '0;
        produce = 1'b0;
        unique case (command)
            lcd4_pkg::CMD_INIT: begin
                entry.is_init = 1'b1;
                produce       = 1'b1;
            end
            lcd4_pkg::CMD_SET_POS: begin
                if (!row[2]) begin
                    entry.split      = mode_reg;
                    entry.code       = lcd4_pkg::OP_SET_DDRAM |
                                       {1'b0, lcd4_pkg::line_base(row[1:0]) + {1'b0, column}};
                    entry.wait_after = lcd4_pkg::WAIT_CMD_MS;
                    produce          = 1'b1;
                end
            end
            lcd4_pkg::CMD_WRITE_CHAR: begin
                entry.reg_select = 1'b1;
                entry.split      = mode_reg;
                entry.code       = char_code;
                produce          = 1'b1;
            end
            default: produce = 1'b0;
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        if (accept && (command == lcd4_pkg::CMD_INIT)) begin
            mode_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
        end
    end

endmodule

// File: hdl/lcd4_queue.sv
module lcd4_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lcd4_pkg::entry_t    push_entry,
    input  logic                pop,
    output lcd4_pkg::entry_t    head,
    output lcd4_pkg::q_status_t status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcd4_pkg::entry_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/lcd4_back.sv
module lcd4_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcd4_pkg::entry_t    head,
    input  lcd4_pkg::q_status_t q_stat,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output lcd4_pkg::strobe_t   out_strobe
);

    logic [lcd4_pkg::STEP_W-1:0] step_reg;
    logic [lcd4_pkg::STEP_W-1:0] step_next;
    logic                        valid_reg;
    logic                        valid_next;
    lcd4_pkg::strobe_t           strobe_reg;
    lcd4_pkg::strobe_t           strobe;
    logic                        load;

    assign load       = ~q_stat.empty & (~valid_reg | out_ready);
    assign q_pop      = load & strobe.last;
    assign out_valid  = valid_reg;
    assign out_strobe = strobe_reg;

    always_comb begin
        strobe = '0;
        if (head.is_init) begin
            strobe = lcd4_pkg::init_strobe(step_reg);
        end else begin
            strobe.reg_select = head.reg_select;
            if (head.split && (step_reg == '0)) begin
                strobe.nibble = head.code[7:4];
            end else begin
                strobe.nibble     = head.split ? head.code[3:0] : head.code[7:4];
                strobe.wait_after = head.wait_after;
                strobe.last       = 1'b1;
            end
        end
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = strobe.last ? '0 : step_reg + 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            strobe_reg <= strobe;
        end
    end

endmodule

// File: verif/char_lcd_nibble_write_sequencer_core_tb.sv
`timescale 1ns / 100ps

module char_lcd_nibble_write_sequencer_core_tb;

    // Command code three is not used by the block. It must be swallowed
    // without producing a strobe.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Number of quiet cycles at the end. It lets a late or spurious strobe
    // show up before the verdict is printed.
    localparam int TAIL_CYCLES = 40;

    // The watchdog ends the run after this many cycles in which neither
    // channel completes a transaction.
    localparam int STALL_LIMIT = 5000;

    // In this range of accepted commands, neither side inserts gaps.
    localparam int CALM_FIRST = 150;
    localparam int CALM_LAST  = 230;

    // One command waiting to be driven. When hold_for_drain is set, the driver
    // keeps the input channel idle until every predicted strobe has been seen.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [2:0] row;
        logic       hold_for_drain;
    } lcd_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    lcd_cmd_t          cmds_pending[$];
    lcd4_pkg::strobe_t strobes_due[$];

    // Model of the display's interface mode, as the block should track it.
    logic lcd_in_4bit = 1'b0;

    logic cmd_taken = 1'b0;
    int   cmds_accepted = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    char_lcd_nibble_write_sequencer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Queues the strobes for one byte. In 4-bit mode the byte goes out as the
    // high nibble and then the low nibble. The wait before is attached to the
    // first strobe, and the wait after and the end-of-command flag go with the
    // second. Before the switch to 4-bit mode, only the high nibble goes out,
    // and it carries everything.
    task automatic send_byte(input logic rs, input logic [7:0] code,
                             input logic [5:0] before_ms, input logic [2:0] after_ms,
                             input logic fin);
        lcd4_pkg::strobe_t s;
        s.reg_select  = rs;
        s.nibble      = code[7:4];
        s.wait_before = before_ms;
        if (lcd_in_4bit) begin
            s.wait_after = '0;
            s.last       = 1'b0;
            strobes_due.push_back(s);
            s.nibble      = code[3:0];
            s.wait_before = '0;
        end
        s.wait_after = after_ms;
        s.last       = fin;
        strobes_due.push_back(s);
    endtask

    // Predicts every strobe caused by one accepted command.
    task automatic predict_strobes(input logic [1:0] cmd, input logic [7:0] char_code,
                                   input logic [5:0] column, input logic [2:0] row);
        logic [6:0] base;
        logic [6:0] addr;
        case (cmd)
            lcd4_pkg::CMD_INIT: begin
                // The wake-up codes are sent as single high nibbles. After
                // that, the display runs in 4-bit mode for the rest of setup.
                lcd_in_4bit = 1'b0;
                send_byte(1'b0, lcd4_pkg::CODE_FS_8BIT, lcd4_pkg::WAIT_POWER_UP_MS,
                          lcd4_pkg::WAIT_FIRST_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::CODE_FS_8BIT, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::CODE_FS_8BIT, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::OP_FUNCTION_SET, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                lcd_in_4bit = 1'b1;
                send_byte(1'b0, lcd4_pkg::CODE_FS_2LINE, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::CODE_DISP_OFF, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::OP_CLEAR, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::CODE_ENTRY, '0, lcd4_pkg::WAIT_CMD_MS, 1'b0);
                send_byte(1'b0, lcd4_pkg::CODE_DISP_ON, '0, lcd4_pkg::WAIT_CMD_MS, 1'b1);
            end
            lcd4_pkg::CMD_SET_POS: begin
                // Rows above three have no line, so nothing is sent. The
                // address wraps within seven bits.
                if (row < 3'd4) begin
                    case (row[1:0])
                        2'd0: base = 7'd0;
                        2'd1: base = 7'd64;
                        2'd2: base = 7'd20;
                        default: base = 7'd84;
                    endcase
                    addr = base + {1'b0, column};
                    send_byte(1'b0, lcd4_pkg::OP_SET_DDRAM | {1'b0, addr}, '0,
                              lcd4_pkg::WAIT_CMD_MS, 1'b1);
                end
            end
            lcd4_pkg::CMD_WRITE_CHAR: send_byte(1'b1, char_code, '0, '0, 1'b1);
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] char_code,
                             input logic [5:0] column, input logic [2:0] row,
                             input logic hold_for_drain);
        lcd_cmd_t c;
        c.cmd            = cmd;
        c.char_code      = char_code;
        c.column         = column;
        c.row            = row;
        c.hold_for_drain = hold_for_drain;
        cmds_pending.push_back(c);
    endtask

    // Command driver. Inputs change on the falling edge. A new command is
    // offered only after the previous one has been taken, so valid stays high
    // until the handshake completes.
    always @(negedge aclk) begin : drive_cmds
        lcd_cmd_t c;
        logic     gap;
        gap = !(cmds_accepted >= CALM_FIRST && cmds_accepted < CALM_LAST)
              && ($urandom_range(99) < 22);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || cmd_taken) begin
            if (cmds_pending.size() == 0 || gap) begin
                s_tvalid <= 1'b0;
            end else if (cmds_pending[0].hold_for_drain && strobes_due.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                c = cmds_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, c.row, c.column, c.char_code, c.cmd};
            end
        end
    end

    // The strobe receiver stalls at random, except during the calm stretch.
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (cmds_accepted >= CALM_FIRST && cmds_accepted < CALM_LAST)
                        || ($urandom_range(99) >= 22);
        end
    end

    // Scoreboard and watchdog, both on the rising edge. The block registers its
    // output, so a strobe is checked before the command accepted on the same
    // edge is predicted. A command cannot produce a strobe on the edge where it
    // is accepted.
    always @(posedge aclk) begin : check_strobes
        lcd4_pkg::strobe_t got;
        lcd4_pkg::strobe_t want;
        logic              out_fire;
        logic              in_fire;
        out_fire = aresetn && m_tvalid && m_tready;
        in_fire  = aresetn && s_tvalid && s_tready;
        if (out_fire) begin
            got.reg_select  = m_tdata[0];
            got.nibble      = m_tdata[4:1];
            got.wait_before = m_tdata[10:5];
            got.wait_after  = m_tdata[13:11];
            got.last        = m_tlast;
            if (strobes_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("strobe with none expected: rs=%0d nib=%h wb=%0d wa=%0d last=%0d",
                             got.reg_select, got.nibble, got.wait_before, got.wait_after,
                             got.last);
            end else begin
                want = strobes_due.pop_front();
                if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
                    got.wait_before !== want.wait_before ||
                    got.wait_after !== want.wait_after || got.last !== want.last) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("strobe differs: exp %0d %h %0d %0d %0d got %0d %h %0d %0d %0d",
                                 want.reg_select, want.nibble, want.wait_before,
                                 want.wait_after, want.last, got.reg_select, got.nibble,
                                 got.wait_before, got.wait_after, got.last);
                end
            end
        end
        if (in_fire) begin
            predict_strobes(s_tdata[1:0], s_tdata[9:2], s_tdata[15:10], s_tdata[18:16]);
            cmds_accepted = cmds_accepted + 1;
        end
        cmd_taken <= in_fire;

        if (!aresetn || in_fire || out_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("char_lcd_nibble_write_sequencer_core: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [1:0] cmd;
        logic [5:0] column;
        logic [2:0] row;
        int         pick;

        // Directed part. Before initialization, both position and character
        // commands send only the high nibble.
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'hFF, 6'd0, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'h00, 6'd63, 3'd7, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd5, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'hFF, 6'd0, 3'd4, 1'b0);
        queue_cmd(CMD_UNUSED, 8'hFF, 6'd63, 3'd7, 1'b0);
        queue_cmd(lcd4_pkg::CMD_INIT, 8'h00, 6'd0, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd0, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd39, 3'd1, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd39, 3'd2, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd39, 3'd3, 1'b0);
        // Columns past the line length can wrap the address within seven bits.
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd63, 3'd3, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd63, 3'd1, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd0, 3'd7, 1'b0);
        queue_cmd(lcd4_pkg::CMD_SET_POS, 8'h00, 6'd63, 3'd5, 1'b0);
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'h00, 6'd0, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'hFF, 6'd0, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'hA5, 6'd0, 3'd0, 1'b0);
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'h5A, 6'd0, 3'd0, 1'b0);
        queue_cmd(CMD_UNUSED, 8'h00, 6'd0, 3'd0, 1'b0);
        // A second initialization starts while the block is already in 4-bit mode.
        queue_cmd(lcd4_pkg::CMD_INIT, 8'hFF, 6'd63, 3'd7, 1'b0);
        queue_cmd(lcd4_pkg::CMD_WRITE_CHAR, 8'h41, 6'd0, 3'd0, 1'b0);

        // Random part. Most commands are position and character writes, with
        // an occasional re-initialization and some commands that are ignored.
        // The sender drains the strobe queue twice: once at the start of this
        // part and once deep inside it.
        for (int i = 0; i < 310; i++) begin
            pick   = $urandom_range(99);
            column = ($urandom_range(9) < 8) ? 6'($urandom_range(39)) : 6'($urandom_range(63));
            row    = ($urandom_range(9) < 9) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
            if (pick < 3)
                cmd = lcd4_pkg::CMD_INIT;
            else if (pick < 6)
                cmd = CMD_UNUSED;
            else if (pick < 45)
                cmd = lcd4_pkg::CMD_SET_POS;
            else
                cmd = lcd4_pkg::CMD_WRITE_CHAR;
            queue_cmd(cmd, 8'($urandom_range(255)), column, row, (i == 0) || (i == 250));
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmds_pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (strobes_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (strobes_due.size() != 0)
            mismatches = mismatches + 1;
        if (mismatches == 0)
            $display("char_lcd_nibble_write_sequencer_core: match");
        else
            $display("char_lcd_nibble_write_sequencer_core: mismatch");
        $finish;
    end

endmodule

// File: char_lcd_nibble_write_sequencer_core.f
hdl/lcd4_pkg.sv
hdl/lcd4_front.sv
hdl/lcd4_queue.sv
hdl/lcd4_back.sv
hdl/char_lcd_nibble_write_sequencer_core.sv
verif/char_lcd_nibble_write_sequencer_core_tb.sv
